[hdl/sv39ptw_pkg.sv]
// Shared types and constants of the Sv39 page table walker.
`default_nettype none
package sv39ptw_pkg;

    // Field widths.
    localparam int unsigned XLEN      = 64;
    localparam int unsigned PPN_W     = 44;
    localparam int unsigned IDX_W     = 9;
    localparam int unsigned RADDR_W   = 56;
    localparam int unsigned MODE_LSB  = 60;
    localparam int unsigned PTE_PPN_LSB = 10;

    // Request opcodes.
    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_RESPONSE  = 1'b1;

    // Result kinds.
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Walk levels.
    localparam logic [1:0] LVL_0    = 2'd0;
    localparam logic [1:0] LVL_1    = 2'd1;
    localparam logic [1:0] LVL_ROOT = 2'd2;

    // Bit positions inside a page table entry.
    localparam int unsigned PTE_V = 0;
    localparam int unsigned PTE_R = 1;
    localparam int unsigned PTE_W = 2;
    localparam int unsigned PTE_X = 3;

    // One input request.
    typedef struct packed {
        logic             opcode;
        logic [XLEN-1:0]  virt_addr;
        logic [XLEN-1:0]  entry_data;
    } t_in_item;

    // One result request.
    typedef struct packed {
        logic               result_kind;
        logic [RADDR_W-1:0] read_address;
        logic [XLEN-1:0]    phys_addr;
        logic               fault;
    } t_out_item;

    // Walk state carried between requests.
    typedef struct packed {
        logic            busy;
        logic [1:0]      walk_level;
        logic [XLEN-1:0] saved_vaddr;
    } t_walk_state;

endpackage
`default_nettype wire

[hdl/sv39ptw_in_if.sv]
// Input channel of the walker: translate requests and memory read responses.
`default_nettype none
interface sv39ptw_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [63:0] virt_addr;
    logic [63:0] entry_data;

    modport source (output valid, output opcode, output virt_addr, output entry_data,
                    input ready);
    modport sink   (input valid, input opcode, input virt_addr, input entry_data,
                    output ready);
endinterface
`default_nettype wire

[hdl/sv39ptw_out_if.sv]
// Output channel of the walker: memory read requests and finished translations.
`default_nettype none
interface sv39ptw_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [55:0] read_address;
    logic [63:0] phys_addr;
    logic        fault;

    modport source (output valid, output result_kind, output read_address,
                    output phys_addr, output fault, input ready);
    modport sink   (input valid, input result_kind, input read_address,
                    input phys_addr, input fault, output ready);
endinterface
`default_nettype wire

[hdl/sv39_page_table_walker_unit.sv]
// Sv39 page table walker: input register, walk step logic and result register.
// A request accepted into the input register passes the walk step logic, then
// the result register, before it reaches the output.
// Throughput: one request per cycle unless a stalled receiver holds the result;
// the walk state updates as each request moves on, so the next one sees it at once.
// Reset (synchronous, active low) clears both valid flags, the walk state
// (idle, root level, saved address zero) and the translation control register.
`default_nettype none
module sv39_page_table_walker_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [63:0] i_cfg_wdata,
    sv39ptw_in_if.sink       i_req,
    sv39ptw_out_if.source    o_res
);

    logic                     r_s1_valid;
    sv39ptw_pkg::t_in_item    r_s1_item;
    logic                     r_out_valid;
    sv39ptw_pkg::t_out_item   r_out_item;
    sv39ptw_pkg::t_walk_state r_state;
    logic [63:0]              r_satp;

    sv39ptw_pkg::t_walk_state n_state;
    sv39ptw_pkg::t_out_item   n_out_item;
    logic                     n_out_valid;
    logic                     w_adv;

    // The registered request moves on when the result register is free or emptying.
    assign w_adv       = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_s1_valid || w_adv;

    // Translation control register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_satp <= '0;
        end else if (i_cfg_we) begin
            r_satp <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_s1_item.opcode     <= i_req.opcode;
            r_s1_item.virt_addr  <= i_req.virt_addr;
            r_s1_item.entry_data <= i_req.entry_data;
        end
    end

    // Walk step logic.
    sv39ptw_step u_step (
        .i_state      (r_state),
        .i_satp       (r_satp),
        .i_item       (r_s1_item),
        .o_next_state (n_state),
        .o_res_valid  (n_out_valid),
        .o_res        (n_out_item)
    );

    // Walk state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.busy        <= 1'b0;
            r_state.walk_level  <= sv39ptw_pkg::LVL_ROOT;
            r_state.saved_vaddr <= '0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= n_out_valid;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && n_out_valid) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.result_kind  = r_out_item.result_kind;
    assign o_res.read_address = r_out_item.read_address;
    assign o_res.phys_addr    = r_out_item.phys_addr;
    assign o_res.fault        = r_out_item.fault;

endmodule
`default_nettype wire

[hdl/sv39ptw_step.sv]
// Walk step logic: next walk state and result for one registered request.
`default_nettype none
module sv39ptw_step (
    input  wire sv39ptw_pkg::t_walk_state i_state,
    input  wire logic [63:0]              i_satp,
    input  wire sv39ptw_pkg::t_in_item    i_item,
    output sv39ptw_pkg::t_walk_state      o_next_state,
    output logic                          o_res_valid,
    output sv39ptw_pkg::t_out_item        o_res
);

    logic [sv39ptw_pkg::PPN_W-1:0] w_pte_ppn;
    logic [sv39ptw_pkg::PPN_W-1:0] w_root_ppn;
    logic [sv39ptw_pkg::IDX_W-1:0] w_next_idx;
    logic [1:0]                    w_next_level;
    logic                          w_pte_v;
    logic                          w_pte_rwx;
    logic [63:0]                   w_leaf_offset;

    // Entry fields and the root page number.
    assign w_pte_ppn  = i_item.entry_data[sv39ptw_pkg::PTE_PPN_LSB +: sv39ptw_pkg::PPN_W];
    assign w_root_ppn = i_satp[sv39ptw_pkg::PPN_W-1:0];
    assign w_pte_v    = i_item.entry_data[sv39ptw_pkg::PTE_V];
    assign w_pte_rwx  = i_item.entry_data[sv39ptw_pkg::PTE_R]
                      | i_item.entry_data[sv39ptw_pkg::PTE_W]
                      | i_item.entry_data[sv39ptw_pkg::PTE_X];

    // The level below a non-leaf entry; anything above level one steps to level one.
    assign w_next_level = (i_state.walk_level >= sv39ptw_pkg::LVL_ROOT) ?
                          sv39ptw_pkg::LVL_1 : sv39ptw_pkg::LVL_0;

    // Index of the next entry, taken from the saved address.
    always_comb begin
        if (w_next_level == sv39ptw_pkg::LVL_0) begin
            w_next_idx = i_state.saved_vaddr[20:12];
        end else begin
            w_next_idx = i_state.saved_vaddr[29:21];
        end
    end

    // Page offset kept from the saved address for a leaf at this level.
    always_comb begin
        case (i_state.walk_level)
            sv39ptw_pkg::LVL_0: w_leaf_offset = {52'd0, i_state.saved_vaddr[11:0]};
            sv39ptw_pkg::LVL_1: w_leaf_offset = {43'd0, i_state.saved_vaddr[20:0]};
            default:            w_leaf_offset = {34'd0, i_state.saved_vaddr[29:0]};
        endcase
    end

    // Request decode and state update.
    always_comb begin
        o_next_state = i_state;
        o_res_valid  = 1'b0;
        o_res        = '0;
        if (i_item.opcode == sv39ptw_pkg::OP_TRANSLATE) begin
            if (!i_state.busy) begin
                o_res_valid = 1'b1;
                if (i_satp[63:sv39ptw_pkg::MODE_LSB] == 4'd0) begin
                    // Translation off: pass the address through.
                    o_res.result_kind = sv39ptw_pkg::KIND_DONE;
                    o_res.phys_addr   = i_item.virt_addr;
                end else begin
                    // Start a walk at the root table.
                    o_next_state.busy        = 1'b1;
                    o_next_state.walk_level  = sv39ptw_pkg::LVL_ROOT;
                    o_next_state.saved_vaddr = i_item.virt_addr;
                    o_res.result_kind  = sv39ptw_pkg::KIND_READ;
                    o_res.read_address = {w_root_ppn, i_item.virt_addr[38:30], 3'b000};
                end
            end
        end else if (i_state.busy) begin
            o_res_valid = 1'b1;
            if (!w_pte_v) begin
                // Invalid entry ends the walk with a fault.
                o_next_state.busy       = 1'b0;
                o_next_state.walk_level = sv39ptw_pkg::LVL_ROOT;
                o_res.result_kind = sv39ptw_pkg::KIND_DONE;
                o_res.fault       = 1'b1;
            end else if (i_state.walk_level == sv39ptw_pkg::LVL_0 || w_pte_rwx) begin
                // Leaf entry: form the physical address.
                o_next_state.busy       = 1'b0;
                o_next_state.walk_level = sv39ptw_pkg::LVL_ROOT;
                o_res.result_kind = sv39ptw_pkg::KIND_DONE;
                o_res.phys_addr   = {8'd0, w_pte_ppn, 12'd0} | w_leaf_offset;
            end else begin
                // Pointer entry: read one level down.
                o_next_state.walk_level = w_next_level;
                o_res.result_kind  = sv39ptw_pkg::KIND_READ;
                o_res.read_address = {w_pte_ppn, w_next_idx, 3'b000};
            end
        end
    end

endmodule
`default_nettype wire

[tb/sv39_page_table_walker_unit_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the Sv39 page table walker with directed and random walks.

// Tracks the walk state and holds the results the walker still owes.
class translation_checker;
    logic [63:0]            satp_value;
    logic                   walk_active;
    logic [1:0]             walk_depth;
    logic [63:0]            walk_vaddr;
    sv39ptw_pkg::t_out_item awaited_results[$];
    int                     fail_count;

    function new();
        satp_value  = '0;
        walk_active = 1'b0;
        walk_depth  = sv39ptw_pkg::LVL_ROOT;
        walk_vaddr  = '0;
        fail_count  = 0;
    endfunction

    // Byte address of the entry at the given level, indexed by the saved address.
    function logic [55:0] entry_address(logic [43:0] table_ppn, logic [1:0] lvl);
        logic [8:0] idx;
        case (lvl)
            sv39ptw_pkg::LVL_0: idx = walk_vaddr[20:12];
            sv39ptw_pkg::LVL_1: idx = walk_vaddr[29:21];
            default:            idx = walk_vaddr[38:30];
        endcase
        return {table_ppn, idx, 3'b000};
    endfunction

    // Advances the walk by one accepted request. Returns 1 when a result is due.
    function bit take_request(sv39ptw_pkg::t_in_item req);
        sv39ptw_pkg::t_out_item res;
        logic [43:0]            ppn;
        logic [63:0]            offset_mask;
        logic [2:0]             rwx;
        res = '0;
        if (req.opcode == sv39ptw_pkg::OP_TRANSLATE) begin
            // A translate request during a walk is dropped.
            if (walk_active) return 1'b0;
            if (satp_value[63:60] == 4'd0) begin
                res.result_kind = sv39ptw_pkg::KIND_DONE;
                res.phys_addr   = req.virt_addr;
            end else begin
                walk_vaddr       = req.virt_addr;
                walk_active      = 1'b1;
                walk_depth       = sv39ptw_pkg::LVL_ROOT;
                res.result_kind  = sv39ptw_pkg::KIND_READ;
                res.read_address = entry_address(satp_value[43:0], sv39ptw_pkg::LVL_ROOT);
            end
        end else begin
            // A read response with no walk in progress is dropped.
            if (!walk_active) return 1'b0;
            ppn = req.entry_data[53:10];
            rwx = req.entry_data[sv39ptw_pkg::PTE_X : sv39ptw_pkg::PTE_R];
            if (!req.entry_data[sv39ptw_pkg::PTE_V]) begin
                walk_active     = 1'b0;
                walk_depth      = sv39ptw_pkg::LVL_ROOT;
                res.result_kind = sv39ptw_pkg::KIND_DONE;
                res.fault       = 1'b1;
            end else if (walk_depth == sv39ptw_pkg::LVL_0 || rwx != 3'b000) begin
                case (walk_depth)
                    sv39ptw_pkg::LVL_0: offset_mask = 64'h0000_0000_0000_0FFF;
                    sv39ptw_pkg::LVL_1: offset_mask = 64'h0000_0000_001F_FFFF;
                    default:            offset_mask = 64'h0000_0000_3FFF_FFFF;
                endcase
                walk_active     = 1'b0;
                walk_depth      = sv39ptw_pkg::LVL_ROOT;
                res.result_kind = sv39ptw_pkg::KIND_DONE;
                res.phys_addr   = {8'h00, ppn, 12'h000} | (walk_vaddr & offset_mask);
            end else begin
                walk_depth       = (walk_depth == sv39ptw_pkg::LVL_ROOT) ?
                                   sv39ptw_pkg::LVL_1 : sv39ptw_pkg::LVL_0;
                res.result_kind  = sv39ptw_pkg::KIND_READ;
                res.read_address = entry_address(ppn, walk_depth);
            end
        end
        awaited_results.push_back(res);
        return 1'b1;
    endfunction

    // Compares one accepted result with the oldest one still owed.
    function void match_result(sv39ptw_pkg::t_out_item seen);
        sv39ptw_pkg::t_out_item want;
        if (awaited_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result: kind=%0d raddr=%h paddr=%h fault=%0d",
                         seen.result_kind, seen.read_address, seen.phys_addr, seen.fault);
            return;
        end
        want = awaited_results.pop_front();
        if (seen.result_kind !== want.result_kind ||
            seen.read_address !== want.read_address ||
            seen.phys_addr !== want.phys_addr || seen.fault !== want.fault) begin
            fail_count++;
            if (fail_count <= 10)
                $display({"mismatch: expected kind=%0d raddr=%h paddr=%h fault=%0d,",
                          " got kind=%0d raddr=%h paddr=%h fault=%0d"},
                         want.result_kind, want.read_address, want.phys_addr, want.fault,
                         seen.result_kind, seen.read_address, seen.phys_addr, seen.fault);
        end
    endfunction
endclass

module sv39_page_table_walker_unit_test;

    localparam int CLK_HALF      = 4;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_RESULTS = 120;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [63:0] i_cfg_wdata;

    sv39ptw_in_if  req_if ();
    sv39ptw_out_if res_if ();

    translation_checker walk_model;

    int cycle_count      = 0;
    int source_calm_left = 0;
    int sink_calm_left   = 0;
    int sink_stall_left  = 0;
    bit sink_hold_ask    = 1'b0;

    sv39_page_table_walker_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    // Free-running clock, 8 ns period.
    always begin
        i_clk = 1'b0;
        #(CLK_HALF);
        i_clk = 1'b1;
        #(CLK_HALF);
    end

    // Hard stop in case the walker hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sv39_page_table_walker_unit verification failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Idle stretch length: mostly short, now and then long.
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) return $urandom_range(1, 3);
        if (pick < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result receiver: random stalls, calm stretches and a long hold-off on demand.
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_ask) begin
                sink_hold_ask   = 1'b0;
                sink_stall_left = HOLD_CYCLES;
            end
            if (sink_stall_left > 0) begin
                res_if.ready <= 1'b0;
                sink_stall_left--;
            end else begin
                res_if.ready <= 1'b1;
                if (sink_calm_left > 0)
                    sink_calm_left--;
                else if ($urandom_range(0, 99) < 3)
                    sink_calm_left = $urandom_range(50, 200);
                else if ($urandom_range(0, 99) < 30)
                    sink_stall_left = gap_length();
            end
        end
    end

    // Every accepted result goes to the checker.
    always @(posedge i_clk) begin
        sv39ptw_pkg::t_out_item seen;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            seen.result_kind  = res_if.result_kind;
            seen.read_address = res_if.read_address;
            seen.phys_addr    = res_if.phys_addr;
            seen.fault        = res_if.fault;
            walk_model.match_result(seen);
        end
    end

    // Offers one request after a random gap and waits until it is accepted.
    task automatic offer(input logic op, input logic [63:0] va, input logic [63:0] pte,
                         output bit caused);
        int                    gap;
        sv39ptw_pkg::t_in_item req;
        if (source_calm_left > 0) begin
            source_calm_left--;
            gap = 0;
        end else if ($urandom_range(0, 99) < 55) begin
            gap = 0;
        end else begin
            gap = gap_length();
        end
        if ($urandom_range(0, 199) == 0)
            source_calm_left = $urandom_range(50, 200);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.opcode     <= op;
        req_if.virt_addr  <= va;
        req_if.entry_data <= pte;
        do @(posedge i_clk); while (!req_if.ready);
        req.opcode     = op;
        req.virt_addr  = va;
        req.entry_data = pte;
        caused = walk_model.take_request(req);
    endtask

    // Stops sending and waits until every owed result has come and the pipe is empty.
    task automatic settle();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (walk_model.awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_control(input logic [63:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        walk_model.satp_value = value;
    endtask

    // Mostly well-formed walks with random entries, plus dropped and stray requests.
    task automatic random_run(input int want_results);
        int          got_results;
        int          kind;
        logic [63:0] va;
        logic [63:0] pte;
        bit          caused;
        got_results = 0;
        while (got_results < want_results) begin
            va  = rand_word();
            pte = rand_word();
            if (walk_model.walk_active) begin
                kind = $urandom_range(0, 99);
                if (kind < 5) begin
                    offer(sv39ptw_pkg::OP_TRANSLATE, va, pte, caused);
                end else begin
                    // Shape the entry: invalid, leaf or pointer to the next table.
                    kind = $urandom_range(0, 99);
                    if (kind < 8) begin
                        pte[sv39ptw_pkg::PTE_V] = 1'b0;
                    end else begin
                        pte[sv39ptw_pkg::PTE_V] = 1'b1;
                        if (walk_model.walk_depth == sv39ptw_pkg::LVL_0) begin
                            if ($urandom_range(0, 1) == 0) pte[3:1] = 3'b000;
                        end else if (kind < 28) begin
                            pte[3:1] = 3'($urandom_range(1, 7));
                        end else if (kind < 95) begin
                            pte[3:1] = 3'b000;
                        end
                    end
                    case ($urandom_range(0, 15))
                        0:       pte[53:10] = '0;
                        1:       pte[53:10] = '1;
                        default: ;
                    endcase
                    offer(sv39ptw_pkg::OP_RESPONSE, va, pte, caused);
                end
            end else if ($urandom_range(0, 99) < 10) begin
                offer(sv39ptw_pkg::OP_RESPONSE, va, pte, caused);
            end else begin
                case ($urandom_range(0, 15))
                    0:       va = '0;
                    1:       va = '1;
                    default: ;
                endcase
                offer(sv39ptw_pkg::OP_TRANSLATE, va, pte, caused);
            end
            if (caused) got_results++;
            if ($urandom_range(0, 299) == 0) settle();
        end
    endtask

    initial begin
        bit          caused;
        int          phase;
        logic [63:0] r;
        walk_model = new();
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        req_if.valid      <= 1'b0;
        req_if.opcode     <= sv39ptw_pkg::OP_TRANSLATE;
        req_if.virt_addr  <= '0;
        req_if.entry_data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Translation off after reset: addresses pass through, a stray response is dropped.
        offer(sv39ptw_pkg::OP_TRANSLATE, '1, rand_word(), caused);
        offer(sv39ptw_pkg::OP_TRANSLATE, '0, rand_word(), caused);
        offer(sv39ptw_pkg::OP_RESPONSE, rand_word(), rand_word(), caused);
        settle();

        // Sv39 on, root table at page zero.
        write_control({4'h8, 16'hFFFF, 44'h0});
        // Root entry invalid: fault.
        offer(sv39ptw_pkg::OP_TRANSLATE, '1, rand_word(), caused);
        offer(sv39ptw_pkg::OP_RESPONSE, rand_word(), 64'hFFFF_FFFF_FFFF_FFFE, caused);
        // Gigapage leaf with the largest page number.
        offer(sv39ptw_pkg::OP_TRANSLATE, rand_word(), rand_word(), caused);
        offer(sv39ptw_pkg::OP_RESPONSE, rand_word(),
              {10'h0, 44'hFFF_FFFF_FFFF, 6'h0, 4'b0011}, caused);
        // Pointer at the root, then a megapage leaf with X only.
        offer(sv39ptw_pkg::OP_TRANSLATE, '1, rand_word(), caused);
        offer(sv39ptw_pkg::OP_RESPONSE, rand_word(),
              {10'h3FF, 44'hFFF_FFFF_FFFF, 6'h3F, 4'b0001}, caused);
        offer(sv39ptw_pkg::OP_RESPONSE, rand_word(),
              {10'h0, 44'h123_4567_89AB, 6'h0, 4'b1001}, caused);
        // Full walk down to a level-0 entry with no R/W/X and page number zero.
        offer(sv39ptw_pkg::OP_TRANSLATE, rand_word(), rand_word(), caused);
        offer(sv39ptw_pkg::OP_RESPONSE, rand_word(), 64'h1, caused);
        offer(sv39ptw_pkg::OP_RESPONSE, rand_word(), 64'h1, caused);
        offer(sv39ptw_pkg::OP_RESPONSE, rand_word(), 64'h1, caused);
        // Translate request during a walk is dropped; level-0 entry invalid.
        offer(sv39ptw_pkg::OP_TRANSLATE, rand_word(), rand_word(), caused);
        offer(sv39ptw_pkg::OP_RESPONSE, rand_word(), {rand_word() & ~64'hF} | 64'h1, caused);
        offer(sv39ptw_pkg::OP_TRANSLATE, rand_word(), rand_word(), caused);
        offer(sv39ptw_pkg::OP_RESPONSE, rand_word(), {rand_word() & ~64'hF} | 64'h1, caused);
        offer(sv39ptw_pkg::OP_RESPONSE, rand_word(), 64'h0, caused);
        // Control register rewritten mid-walk: the walk carries on.
        offer(sv39ptw_pkg::OP_TRANSLATE, rand_word(), rand_word(), caused);
        settle();
        write_control({4'h0, 60'hFFF_FFFF_FFFF_FFFF});
        r = rand_word();
        offer(sv39ptw_pkg::OP_RESPONSE, rand_word(), {10'h0, r[43:0], 6'h0, 4'b0101}, caused);
        offer(sv39ptw_pkg::OP_TRANSLATE, '1, rand_word(), caused);

        // Random phases over a range of control settings.
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            settle();
            r = rand_word();
            case (phase)
                0:       write_control({4'h8, 16'h0000, r[43:0]});
                1:       write_control('1);
                2:       write_control({4'h0, r[59:0]});
                3:       write_control({4'h1, r[59:44], 44'h0});
                4:       write_control({4'h8, r[59:0]});
                5:       write_control(r);
                6:       write_control('0);
                default: write_control({4'($urandom_range(1, 15)), r[59:0]});
            endcase
            // Long receiver hold-off while requests keep coming.
            if (phase == 1 || phase == 4) sink_hold_ask = 1'b1;
            random_run(PHASE_RESULTS);
        end

        settle();
        if (walk_model.fail_count == 0 && walk_model.awaited_results.size() == 0)
            $display("sv39_page_table_walker_unit verification clean");
        else
            $display("sv39_page_table_walker_unit verification failed");
        $finish;
    end

endmodule
